[rtl/core/memory_scan_value_filter_unit_macros.svh]
// Assertion macros used by the checker file of the value filter.
`ifndef MEMORY_SCAN_VALUE_FILTER_UNIT_MACROS_SVH
`define MEMORY_SCAN_VALUE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define MSVF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define MSVF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MSVF_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/msvf_pkg.sv]
`default_nettype none

package msvf_pkg;

    // Width of the saturating kept counter; the port shows its low 32 bits.
    localparam int COUNT_WIDTH = 32;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration port geometry: eight registers at 8-byte spacing.
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // Full 64-bit all-ones pattern.
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Register indexes in the configuration space.
    typedef enum logic [2:0] {
        REG_CONTROL      = 3'd0,
        REG_OPERAND_A    = 3'd1,
        REG_OPERAND_B    = 3'd2,
        REG_IGNORE_VALUE = 3'd3,
        REG_IGNORE_LOW   = 3'd4,
        REG_IGNORE_HIGH  = 3'd5,
        REG_WINDOW_LOW   = 3'd6,
        REG_WINDOW_HIGH  = 3'd7
    } t_reg_idx;

    // Element size codes.
    typedef enum logic [1:0] {
        SZ_1 = 2'd0,
        SZ_2 = 2'd1,
        SZ_4 = 2'd2,
        SZ_8 = 2'd3
    } t_size;

    // Compare kinds held in control bits 4:0.
    typedef enum logic [4:0] {
        CMP_EQ_A        = 5'd0,
        CMP_MASKED_EQ   = 5'd1,
        CMP_INC         = 5'd2,
        CMP_INC_BY      = 5'd3,
        CMP_INC_BY_MIN  = 5'd4,
        CMP_INC_BY_MAX  = 5'd5,
        CMP_DEC         = 5'd6,
        CMP_DEC_BY      = 5'd7,
        CMP_DEC_BY_MIN  = 5'd8,
        CMP_DEC_BY_MAX  = 5'd9,
        CMP_SAME        = 5'd10,
        CMP_BITS_EQ     = 5'd11,
        CMP_DIFF        = 5'd12,
        CMP_NE_A        = 5'd13,
        CMP_CHG_BY      = 5'd14,
        CMP_CHG_BY_MIN  = 5'd15,
        CMP_CHG_BY_MAX  = 5'd16,
        CMP_BITS_NE     = 5'd17,
        CMP_BITS_CHG    = 5'd18,
        CMP_IN_RANGE    = 5'd19,
        CMP_OUT_RANGE   = 5'd20,
        CMP_ANY_SET     = 5'd21,
        CMP_ALL_SET     = 5'd22
    } t_cmp_kind;

    // Filter enable positions within control bits 16:8.
    localparam int EN_WINDOW   = 0;
    localparam int EN_ZERO     = 1;
    localparam int EN_ONES     = 2;
    localparam int EN_VALUE    = 3;
    localparam int EN_IN_RANGE = 4;
    localparam int EN_OUT_RANGE = 5;
    localparam int EN_UPPER    = 6;
    localparam int EN_LOWER    = 7;
    localparam int EN_ESCAPE   = 8;

    // Configuration as seen by the filter logic.
    typedef struct packed {
        logic [16:0] control;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [63:0] ignore_value;
        logic [63:0] ignore_low;
        logic [63:0] ignore_high;
        logic [31:0] window_low;
        logic [31:0] window_high;
    } t_cfg;

    // Decision for one element.
    typedef struct packed {
        logic keep;
        logic count;
    } t_decision;

    // Mask covering the element size.
    function automatic logic [63:0] size_mask(input t_size sz);
        logic [63:0] m;
        case (sz)
            SZ_1:    m = 64'h0000_0000_0000_00FF;
            SZ_2:    m = 64'h0000_0000_0000_FFFF;
            SZ_4:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = ALL_ONES;
        endcase
        return m;
    endfunction

    // Sign extension from the element size.
    function automatic logic [63:0] sext(input logic [63:0] v, input t_size sz);
        logic [63:0] r;
        case (sz)
            SZ_1:    r = {{56{v[7]}}, v[7:0]};
            SZ_2:    r = {{48{v[15]}}, v[15:0]};
            SZ_4:    r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Population count, byte by byte and then summed.
    function automatic logic [6:0] popcount64(input logic [63:0] v);
        logic [3:0] byte_cnt;
        logic [6:0] total;
        total = '0;
        for (int i = 0; i < 8; i++) begin
            byte_cnt = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt = byte_cnt + 4'(v[8*i+j]);
            end
            total = total + 7'(byte_cnt);
        end
        return total;
    endfunction

endpackage

`default_nettype wire

[rtl/core/msvf_regs.sv]
`default_nettype none

module msvf_regs
    import msvf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready,
    output      t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register write decode.
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_CONTROL:      n_cfg.control      = pwdata[16:0];
                REG_OPERAND_A:    n_cfg.operand_a    = pwdata;
                REG_OPERAND_B:    n_cfg.operand_b    = pwdata;
                REG_IGNORE_VALUE: n_cfg.ignore_value = pwdata;
                REG_IGNORE_LOW:   n_cfg.ignore_low   = pwdata;
                REG_IGNORE_HIGH:  n_cfg.ignore_high  = pwdata;
                REG_WINDOW_LOW:   n_cfg.window_low   = pwdata[31:0];
                REG_WINDOW_HIGH:  n_cfg.window_high  = pwdata[31:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    // Configuration registers; the window opens fully on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{window_high: 32'hFFFF_FFFF, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            REG_CONTROL:      prdata = 64'(r_cfg.control);
            REG_OPERAND_A:    prdata = r_cfg.operand_a;
            REG_OPERAND_B:    prdata = r_cfg.operand_b;
            REG_IGNORE_VALUE: prdata = r_cfg.ignore_value;
            REG_IGNORE_LOW:   prdata = r_cfg.ignore_low;
            REG_IGNORE_HIGH:  prdata = r_cfg.ignore_high;
            REG_WINDOW_LOW:   prdata = 64'(r_cfg.window_low);
            REG_WINDOW_HIGH:  prdata = 64'(r_cfg.window_high);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/msvf_filter.sv]
`default_nettype none

module msvf_filter
    import msvf_pkg::*;
(
    input  wire t_cfg        i_cfg,
    input  wire logic [63:0] i_new_value,
    input  wire logic [63:0] i_old_value,
    input  wire logic [31:0] i_mapped_address,
    input  wire logic        i_candidate,
    output      t_decision   o_decision
);

    t_size       sz;
    t_cmp_kind   kind;
    logic [8:0]  en;
    logic        sg;
    logic [63:0] mask;
    logic [63:0] n;
    logic [63:0] o;
    logic [63:0] nn;
    logic [63:0] oo;
    logic [63:0] aa;
    logic [63:0] bb;
    logic [63:0] up;
    logic [63:0] dn;
    logic        n_gt_o;
    logic        n_lt_o;
    logic [6:0]  pc_n;
    logic [6:0]  pc_x;
    logic        pc_n_eq_a;
    logic        pc_x_eq_a;
    logic        size_two;
    logic        drop;
    logic        escape;
    logic        fails;

    assign sz   = t_size'(i_cfg.control[6:5]);
    assign kind = t_cmp_kind'(i_cfg.control[4:0]);
    assign sg   = i_cfg.control[7];
    assign en   = i_cfg.control[16:8];

    // Values masked to the element size, then extended for signed work.
    always_comb begin
        mask = size_mask(sz);
        n    = i_new_value & mask;
        o    = i_old_value & mask;
        nn   = sg ? sext(n, sz) : n;
        oo   = sg ? sext(o, sz) : o;
        aa   = sg ? sext(i_cfg.operand_a, sz) : i_cfg.operand_a;
        bb   = sg ? sext(i_cfg.operand_b, sz) : i_cfg.operand_b;
    end

    // Shared arithmetic for the compare kinds.
    assign up        = oo + aa;
    assign dn        = oo - aa;
    assign n_gt_o    = sg ? ($signed(nn) > $signed(oo)) : (nn > oo);
    assign n_lt_o    = sg ? ($signed(nn) < $signed(oo)) : (nn < oo);
    assign pc_n      = popcount64(nn);
    assign pc_x      = popcount64(nn ^ oo);
    assign pc_n_eq_a = (aa[63:7] == '0) && (pc_n == aa[6:0]);
    assign pc_x_eq_a = (aa[63:7] == '0) && (pc_x == aa[6:0]);
    assign size_two  = (sz == SZ_2);

    // Pre-filter chain in priority order, ending with the equal-values escape.
    always_comb begin
        drop   = 1'b0;
        escape = 1'b0;
        if (en[EN_WINDOW] && ((i_mapped_address < i_cfg.window_low) ||
                              (i_mapped_address > i_cfg.window_high))) begin
            drop = 1'b1;
        end else if (en[EN_ZERO] && (n == '0)) begin
            drop = 1'b1;
        end else if (en[EN_ONES] && (n == mask)) begin
            drop = 1'b1;
        end else if (en[EN_VALUE] && (n == i_cfg.ignore_value)) begin
            drop = 1'b1;
        end else if (en[EN_IN_RANGE] && (n >= i_cfg.ignore_low) &&
                     (n <= i_cfg.ignore_high)) begin
            drop = 1'b1;
        end else if (en[EN_OUT_RANGE] && ((n <= i_cfg.ignore_low) ||
                                          (n >= i_cfg.ignore_high))) begin
            drop = 1'b1;
        end else if (en[EN_UPPER] && size_two && (i_mapped_address[1:0] == 2'b00)) begin
            drop = 1'b1;
        end else if (en[EN_LOWER] && size_two && (i_mapped_address[1:0] != 2'b00)) begin
            drop = 1'b1;
        end else if (en[EN_ESCAPE] && (n == o)) begin
            escape = 1'b1;
        end
    end

    // The search compare; unused kinds always pass.
    always_comb begin
        case (kind)
            CMP_EQ_A:       fails = (nn != aa);
            CMP_MASKED_EQ:  fails = ((nn & bb) != aa);
            CMP_INC:        fails = !n_gt_o;
            CMP_INC_BY:     fails = (nn != up);
            CMP_INC_BY_MIN: fails = (nn < up);
            CMP_INC_BY_MAX: fails = (nn > up) || !n_gt_o;
            CMP_DEC:        fails = !n_lt_o;
            CMP_DEC_BY:     fails = (nn != dn);
            CMP_DEC_BY_MIN: fails = (nn > dn);
            CMP_DEC_BY_MAX: fails = (nn < dn) || !n_lt_o;
            CMP_SAME:       fails = (nn != oo);
            CMP_BITS_EQ:    fails = !pc_n_eq_a;
            CMP_DIFF:       fails = (nn == oo);
            CMP_NE_A:       fails = (nn == aa);
            CMP_CHG_BY:     fails = (nn != dn) && (nn != up);
            CMP_CHG_BY_MIN: fails = (nn > dn) && (nn < up);
            CMP_CHG_BY_MAX: fails = (nn < dn) || (nn > up) || (nn == oo);
            CMP_BITS_NE:    fails = pc_n_eq_a;
            CMP_BITS_CHG:   fails = !pc_x_eq_a;
            CMP_IN_RANGE:   fails = (nn <= aa) || (nn > bb);
            CMP_OUT_RANGE:  fails = (nn >= aa) && (nn <= bb);
            CMP_ANY_SET:    fails = ((nn & aa) == '0);
            CMP_ALL_SET:    fails = ((nn & aa) != aa);
            default:        fails = 1'b0;
        endcase
    end

    // An escaped element is kept but not counted.
    assign o_decision.keep  = i_candidate && (escape || (!drop && !fails));
    assign o_decision.count = i_candidate && !escape && !drop && !fails;

endmodule

`default_nettype wire

[rtl/core/memory_scan_value_filter_unit.sv]
// An accepted input transaction passes the input register and then the result register, which offers it.
// Throughput: one element per cycle unless stalled; input register, filter logic and result register.
// The input side stalls only while the input register is full and a waiting result is held back.
// Reset (synchronous, active low) empties both registers, clears the kept count and
// returns the configuration registers to their reset values.
`default_nettype none

module memory_scan_value_filter_unit
    import msvf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Element input channel.
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire logic [63:0]       i_new_value,
    input  wire logic [63:0]       i_old_value,
    input  wire logic [31:0]       i_mapped_address,
    input  wire logic              i_candidate_in,
    input  wire logic              i_scan_start,
    // Result channel.
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      logic              o_candidate_out,
    output      logic [31:0]       o_candidate_count,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready
);

    t_cfg                   cfg;
    t_decision              dec;

    logic                   r_s1_valid;
    logic [63:0]            r_s1_new;
    logic [63:0]            r_s1_old;
    logic [31:0]            r_s1_addr;
    logic                   r_s1_cand;
    logic                   r_s1_start;

    logic                   r_out_valid;
    logic                   r_out_keep;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] count_base;
    logic [63:0]            count_wide;

    logic                   advance;
    logic                   in_accept;

    msvf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msvf_filter u_filter (
        .i_cfg            (cfg),
        .i_new_value      (r_s1_new),
        .i_old_value      (r_s1_old),
        .i_mapped_address (r_s1_addr),
        .i_candidate      (r_s1_cand),
        .o_decision       (dec)
    );

    // Handshake: the result register frees whenever it is empty or being taken.
    assign advance   = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_new   <= i_new_value;
            r_s1_old   <= i_old_value;
            r_s1_addr  <= i_mapped_address;
            r_s1_cand  <= i_candidate_in;
            r_s1_start <= i_scan_start;
        end
    end

    // Saturating kept count, restarted by the first element of a scan.
    always_comb begin
        count_base = r_s1_start ? '0 : r_count;
        n_count    = count_base;
        if (dec.count && (count_base != COUNT_MAX)) begin
            n_count = count_base + 1'b1;
        end
    end

    // Result register and count state move together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_keep <= dec.keep;
        end
    end

    assign count_wide        = 64'(r_count);
    assign o_valid           = r_out_valid;
    assign o_candidate_out   = r_out_keep;
    assign o_candidate_count = count_wide[31:0];

endmodule

`default_nettype wire

[rtl/core/msvf_checker.sv]
`default_nettype none

`include "memory_scan_value_filter_unit_macros.svh"

module msvf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_candidate_out,
    input wire logic [31:0] o_candidate_count
);

    // A result that is held back stays offered.
    `MSVF_ASSERT_NEXT(a_out_valid_held, o_valid && i_stall, o_valid, "result dropped while stalled")

    // A held-back result keeps its payload.
    `MSVF_ASSERT_NEXT(a_out_payload_held, o_valid && i_stall, $stable(o_candidate_out) && $stable(o_candidate_count), "result payload changed while stalled")

    // The input side only stalls when a result is waiting and being held back.
    `MSVF_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without a waiting result")

    // An offered transaction is taken whenever no result is waiting.
    `MSVF_ASSERT_IMP(a_take_when_free, i_valid && !o_valid, !o_stall, "transaction refused")

    // Reset leaves both channels quiet.
    `MSVF_ASSERT_RST(a_reset_empty, !i_rst_n, !o_valid && !o_stall, "pipeline not empty after reset")

endmodule

bind memory_scan_value_filter_unit msvf_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_candidate_out   (o_candidate_out),
    .o_candidate_count (o_candidate_count)
);

`default_nettype wire

[tb/candidate_filter_checker.sv]
// Watches the element and result channels of the value filter, keeps a model of
// its configuration and kept count, and compares every result transaction.
module candidate_filter_checker import msvf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic [63:0]       i_new_value,
    input  logic [63:0]       i_old_value,
    input  logic [31:0]       i_mapped_address,
    input  logic              i_candidate_in,
    input  logic              i_scan_start,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic              o_candidate_out,
    input  logic [31:0]       o_candidate_count,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                error_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        keep;
        logic [31:0] count;
    } verdict_t;

    // Shadow of the configuration registers and of the kept counter.
    logic [16:0]            ctl_q;
    logic [63:0]            opa_q;
    logic [63:0]            opb_q;
    logic [63:0]            ign_value_q;
    logic [63:0]            ign_low_q;
    logic [63:0]            ign_high_q;
    logic [31:0]            win_low_q;
    logic [31:0]            win_high_q;
    logic [COUNT_WIDTH-1:0] kept_total;

    verdict_t expected_verdicts[$];
    int       mismatch_total = 0;
    int       pending_q = 0;

    assign error_count   = mismatch_total;
    assign pending_count = pending_q;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_total++;
    endtask

    // Ones over the value bits of the element size.
    function automatic logic [63:0] lane_mask(input t_size sz);
        return (sz == SZ_8) ? '1 : ((64'd1 << (8 << sz)) - 64'd1);
    endfunction

    // Extends the top bit of the element across the whole word.
    function automatic logic [63:0] widen_signed(input logic [63:0] v, input t_size sz);
        int          bits;
        logic [63:0] m;
        bits = 8 << sz;
        m    = lane_mask(sz);
        if (sz != SZ_8 && v[bits-1]) begin
            return v | ~m;
        end
        return v & m;
    endfunction

    function automatic logic [63:0] ones_in(input logic [63:0] v);
        logic [63:0] c;
        c = '0;
        for (int i = 0; i < 64; i++) begin
            c += 64'(v[i]);
        end
        return c;
    endfunction

    // Works out the decision for one element and advances the kept counter.
    function automatic verdict_t predict_candidate(input logic [63:0] nv, input logic [63:0] ov,
                                                   input logic [31:0] addr, input logic cand,
                                                   input logic start);
        t_size       sz;
        logic [63:0] m, n, o, a, b, up, dn;
        logic [8:0]  en;
        logic        sg, keep, counted, drop, escape, gt, lt;
        verdict_t    r;
        sz      = t_size'(ctl_q[6:5]);
        m       = lane_mask(sz);
        n       = nv & m;
        o       = ov & m;
        sg      = ctl_q[7];
        en      = ctl_q[16:8];
        keep    = 1'b0;
        counted = 1'b0;
        if (start) begin
            kept_total = '0;
        end
        if (cand) begin
            drop   = 1'b0;
            escape = 1'b0;
            // Pre-filters in their fixed order; the first that fires decides.
            if (en[EN_WINDOW] && (addr < win_low_q || addr > win_high_q)) drop = 1'b1;
            else if (en[EN_ZERO] && n == '0) drop = 1'b1;
            else if (en[EN_ONES] && n == m) drop = 1'b1;
            else if (en[EN_VALUE] && n == ign_value_q) drop = 1'b1;
            else if (en[EN_IN_RANGE] && n >= ign_low_q && n <= ign_high_q) drop = 1'b1;
            else if (en[EN_OUT_RANGE] && (n <= ign_low_q || n >= ign_high_q)) drop = 1'b1;
            else if (en[EN_UPPER] && sz == SZ_2 && addr[1:0] == 2'b00) drop = 1'b1;
            else if (en[EN_LOWER] && sz == SZ_2 && addr[1:0] != 2'b00) drop = 1'b1;
            else if (en[EN_ESCAPE] && n == o) escape = 1'b1;

            if (escape) begin
                keep = 1'b1;
            end else if (!drop) begin
                a = opa_q;
                b = opb_q;
                if (sg) begin
                    a = widen_signed(a, sz);
                    b = widen_signed(b, sz);
                    n = widen_signed(n, sz);
                    o = widen_signed(o, sz);
                end
                up = o + a;
                dn = o - a;
                gt = sg ? ($signed(n) > $signed(o)) : (n > o);
                lt = sg ? ($signed(n) < $signed(o)) : (n < o);
                case (ctl_q[4:0])
                    CMP_EQ_A:       keep = (n == a);
                    CMP_MASKED_EQ:  keep = ((n & b) == a);
                    CMP_INC:        keep = gt;
                    CMP_INC_BY:     keep = (n == up);
                    CMP_INC_BY_MIN: keep = (n >= up);
                    CMP_INC_BY_MAX: keep = (n <= up) && gt;
                    CMP_DEC:        keep = lt;
                    CMP_DEC_BY:     keep = (n == dn);
                    CMP_DEC_BY_MIN: keep = (n <= dn);
                    CMP_DEC_BY_MAX: keep = (n >= dn) && lt;
                    CMP_SAME:       keep = (n == o);
                    CMP_BITS_EQ:    keep = (ones_in(n) == a);
                    CMP_DIFF:       keep = (n != o);
                    CMP_NE_A:       keep = (n != a);
                    CMP_CHG_BY:     keep = (n == dn) || (n == up);
                    CMP_CHG_BY_MIN: keep = (n <= dn) || (n >= up);
                    CMP_CHG_BY_MAX: keep = (n >= dn) && (n <= up) && (n != o);
                    CMP_BITS_NE:    keep = (ones_in(n) != a);
                    CMP_BITS_CHG:   keep = (ones_in(n ^ o) == a);
                    CMP_IN_RANGE:   keep = (n > a) && (n <= b);
                    CMP_OUT_RANGE:  keep = !((n >= a) && (n <= b));
                    CMP_ANY_SET:    keep = ((n & a) != '0);
                    CMP_ALL_SET:    keep = ((n & a) == a);
                    // Codes beyond the defined kinds keep everything.
                    default:        keep = 1'b1;
                endcase
                counted = keep;
            end
        end
        if (counted && kept_total != COUNT_MAX) begin
            kept_total = kept_total + 1'b1;
        end
        r.keep  = keep;
        r.count = kept_total[31:0];
        return r;
    endfunction

    // Register writes, result comparison and prediction, once per clock edge.
    always @(posedge i_clk) begin : watch
        verdict_t want;
        if (!i_rst_n) begin
            ctl_q       = '0;
            opa_q       = '0;
            opb_q       = '0;
            ign_value_q = '0;
            ign_low_q   = '0;
            ign_high_q  = '0;
            win_low_q   = '0;
            win_high_q  = 32'hFFFF_FFFF;
            kept_total  = '0;
            expected_verdicts.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:3]))
                    REG_CONTROL:      ctl_q       = pwdata[16:0];
                    REG_OPERAND_A:    opa_q       = pwdata;
                    REG_OPERAND_B:    opb_q       = pwdata;
                    REG_IGNORE_VALUE: ign_value_q = pwdata;
                    REG_IGNORE_LOW:   ign_low_q   = pwdata;
                    REG_IGNORE_HIGH:  ign_high_q  = pwdata;
                    REG_WINDOW_LOW:   win_low_q   = pwdata[31:0];
                    default:          win_high_q  = pwdata[31:0];
                endcase
            end

            // A result transaction is matched against the oldest expectation.
            if (o_valid && !i_stall) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with nothing expected", 64'(o_candidate_out),
                                    64'(o_candidate_count));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_candidate_out !== want.keep) begin
                        report_mismatch("candidate_out", 64'(o_candidate_out), 64'(want.keep));
                    end
                    if (o_candidate_count !== want.count) begin
                        report_mismatch("candidate_count", 64'(o_candidate_count),
                                        64'(want.count));
                    end
                end
            end

            if (i_valid && !o_stall) begin
                expected_verdicts.push_back(predict_candidate(i_new_value, i_old_value,
                                                              i_mapped_address,
                                                              i_candidate_in, i_scan_start));
            end
        end
        pending_q <= expected_verdicts.size();
    end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the value filter; checking lives in the checker.
module tb_top import msvf_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] KIND_UNUSED_FIRST = 5'd23;
    localparam int         PHASES            = 64;

    logic              i_clk;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_stall;
    logic [63:0]       i_new_value      = '0;
    logic [63:0]       i_old_value      = '0;
    logic [31:0]       i_mapped_address = '0;
    logic              i_candidate_in   = 1'b0;
    logic              i_scan_start     = 1'b0;
    logic              o_valid;
    logic              i_stall          = 1'b0;
    logic              o_candidate_out;
    logic [31:0]       o_candidate_count;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [ADDR_W-1:0] paddr            = '0;
    logic [DATA_W-1:0] pwdata           = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int error_count;
    int pending_count;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    memory_scan_value_filter_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_new_value      (i_new_value),
        .i_old_value      (i_old_value),
        .i_mapped_address (i_mapped_address),
        .i_candidate_in   (i_candidate_in),
        .i_scan_start     (i_scan_start),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_candidate_out  (o_candidate_out),
        .o_candidate_count(o_candidate_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    candidate_filter_checker filter_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_new_value      (i_new_value),
        .i_old_value      (i_old_value),
        .i_mapped_address (i_mapped_address),
        .i_candidate_in   (i_candidate_in),
        .i_scan_start     (i_scan_start),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_candidate_out  (o_candidate_out),
        .o_candidate_count(o_candidate_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .error_count      (error_count),
        .pending_count    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // The result side stalls on a pattern that is chosen anew after each random span.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 96);
        end else begin
            stall_span--;
        end
        stall_tick++;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    function automatic logic [16:0] control_word(input logic [4:0] kind, input t_size sz,
                                                 input logic sg, input logic [8:0] en);
        return {en, sg, sz, kind};
    endfunction

    // Random value confined to the element size.
    function automatic logic [63:0] lane_random(input t_size sz);
        return {$urandom, $urandom} >> (64 - (8 << sz));
    endfunction

    function automatic logic [63:0] pick_operand(input t_size sz);
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'($urandom_range(0, 9));
            3:       v = {$urandom, $urandom};
            4:       v = 64'($urandom_range(0, 64));
            5:       v = 64'd1 << ((8 << sz) - 1);
            default: v = lane_random(sz);
        endcase
        return v;
    endfunction

    // New values lean towards the ones that the compares and filters look for.
    function automatic logic [63:0] pick_value(input t_size sz, input logic [63:0] old,
                                               input logic [63:0] a, input logic [63:0] b);
        logic [63:0] v;
        case ($urandom_range(0, 10))
            0:       v = old + 64'($urandom_range(0, 4));
            1:       v = old - 64'($urandom_range(0, 4));
            2:       v = a;
            3:       v = old + a;
            4:       v = old - a;
            5:       v = old;
            6:       v = b;
            7:       v = lane_random(sz) | ({$urandom, $urandom} << (8 << sz));
            8:       v = {$urandom, $urandom};
            9:       v = ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: v = lane_random(sz);
        endcase
        return v;
    endfunction

    // Setup and access cycle of one register write; the select stays up for the next.
    task automatic write_register(input t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic program_phase(input logic [16:0] ctl, input logic [63:0] a,
                                 input logic [63:0] b, input logic [63:0] iv,
                                 input logic [63:0] il, input logic [63:0] ih,
                                 input logic [31:0] wl, input logic [31:0] wh);
        write_register(REG_CONTROL, 64'(ctl));
        write_register(REG_OPERAND_A, a);
        write_register(REG_OPERAND_B, b);
        write_register(REG_IGNORE_VALUE, iv);
        write_register(REG_IGNORE_LOW, il);
        write_register(REG_IGNORE_HIGH, ih);
        write_register(REG_WINDOW_LOW, 64'(wl));
        write_register(REG_WINDOW_HIGH, 64'(wh));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One element transaction, inside a burst or after a random gap.
    task automatic send_element(input logic [63:0] nv, input logic [63:0] ov,
                                input logic [31:0] addr, input logic cand, input logic start);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_new_value      <= nv;
        i_old_value      <= ov;
        i_mapped_address <= addr;
        i_candidate_in   <= cand;
        i_scan_start     <= start;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin : stimulus
        t_size       sz;
        logic        sg;
        logic [8:0]  en;
        logic [16:0] ctl;
        logic [63:0] a, b, iv, il, ih, ov;
        logic [31:0] wl, wh, addr;
        int          items;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, a dropped candidate, masked high bits, unused kind.
        program_phase(control_word(CMP_NE_A, SZ_8, 1'b0, '0), '0, '0, '0, '0, '0,
                      32'h0, 32'hFFFF_FFFF);
        send_element('0, '0, '0, 1'b1, 1'b1);
        send_element('1, '1, '1, 1'b1, 1'b0);
        send_element('1, '0, 32'h8000_0000, 1'b0, 1'b0);
        wait_drained();
        program_phase(control_word(CMP_EQ_A, SZ_1, 1'b0, '0), '0, '0, '0, '0, '0,
                      32'h0, 32'hFFFF_FFFF);
        send_element(64'hFFFF_FFFF_FFFF_FF00, 64'h1, 32'h4, 1'b1, 1'b0);
        wait_drained();
        program_phase(control_word(KIND_UNUSED_FIRST, SZ_4, 1'b1, '0), '1, '1, '0, '0, '0,
                      32'h0, 32'hFFFF_FFFF);
        send_element(64'h1234_5678, 64'h8765_4321, 32'h10, 1'b1, 1'b0);

        // Directed: each pre-filter on its own, at size 2, with a tripping element.
        for (int f = 0; f < 9; f++) begin
            wait_drained();
            program_phase(control_word(CMP_NE_A, SZ_2, 1'b0, 9'(1) << f), 64'd5, '0, '0,
                          '0, 64'd16, 32'h100, 32'h1FF);
            send_element('0, '0, 32'h100, 1'b1, 1'b1);
            send_element(64'hFFFF, 64'hFFFF, 32'h2FE, 1'b1, 1'b0);
        end

        // Random phases: every compare code in turn, random size, sign and filters.
        for (int p = 0; p < PHASES; p++) begin
            sz = t_size'($urandom_range(0, 3));
            sg = 1'($urandom_range(0, 1));
            en = '0;
            for (int k = 0; k < 9; k++) begin
                en[k] = ($urandom_range(0, 4) == 0);
            end
            ctl = control_word(5'(p), sz, sg, en);
            a   = pick_operand(sz);
            b   = ($urandom_range(0, 2) == 0) ? a + lane_random(sz) : pick_operand(sz);
            iv  = pick_operand(sz);
            il  = pick_operand(sz);
            ih  = ($urandom_range(0, 1) == 0) ? il + lane_random(sz) : pick_operand(sz);
            if ($urandom_range(0, 1) == 0) begin
                wl = '0;
                wh = '1;
            end else begin
                wl = $urandom;
                wh = $urandom;
            end
            // The last two phases hold every register at its top and bottom.
            if (p == PHASES - 2) begin
                ctl = '1;
                a   = '1;
                b   = '1;
                iv  = '1;
                il  = '1;
                ih  = '1;
                wl  = '1;
                wh  = '1;
            end else if (p == PHASES - 1) begin
                ctl = '0;
                a   = '0;
                b   = '0;
                iv  = '0;
                il  = '0;
                ih  = '0;
                wl  = '0;
                wh  = '0;
            end
            sz = t_size'(ctl[6:5]);

            wait_drained();
            program_phase(ctl, a, b, iv, il, ih, wl, wh);
            items = $urandom_range(12, 34);
            for (int k = 0; k < items; k++) begin
                ov = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : lane_random(sz);
                case ($urandom_range(0, 5))
                    0:       addr = wl;
                    1:       addr = wh;
                    2:       addr = ($urandom_range(0, 1) == 0) ? wl - 1 : wh + 1;
                    3:       addr = $urandom;
                    default: addr = $urandom_range(wl, wh);
                endcase
                send_element(pick_value(sz, ov, a, b), ov, addr,
                             $urandom_range(0, 9) != 0,
                             (k == 0) || ($urandom_range(0, 31) == 0));
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/msvf_pkg.sv
rtl/core/msvf_regs.sv
rtl/core/msvf_filter.sv
rtl/core/memory_scan_value_filter_unit.sv
rtl/core/msvf_checker.sv
tb/candidate_filter_checker.sv
tb/tb_top.sv
